[src/twes_pkg.sv]
// ----------------------------------------------------------------------------
// Timing wheel scheduler package
// Shared widths, status codes, default sizes and channel beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package twes_pkg;

   localparam int EVENT_BITS   = 48;
   localparam int SECOND_BITS  = 12;
   localparam int AT_BITS      = 16;
   localparam int STATUS_BITS  = 2;

   localparam int DEF_SLOT_COUNT   = 4096;
   localparam int DEF_BUCKET_DEPTH = 8;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_POP      = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_SCHEDULED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DELIVERED = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NONE      = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_DROPPED   = 2'd3;

   typedef struct packed {
      logic                  command;
      logic [AT_BITS-1:0]    slot_time;
      logic [EVENT_BITS-1:0] event_payload;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [SECOND_BITS-1:0] event_second;
      logic [EVENT_BITS-1:0]  event_payload_out;
      logic                   last;
      logic                   wheel_empty;
   } rsp_beat_type;

endpackage

`default_nettype wire

[src/timing_wheel_event_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Timing wheel event scheduler
// Linear wheel of one-second slots holding bucketed event words.
// ----------------------------------------------------------------------------
// A request beat either schedules an event word into the slot for its time
// (clamped up to the current time and down to the last slot) or pops the next
// occupied slot. A schedule gives one response beat, from the S_SCHED state
// once the response side is free. A pop of an empty wheel gives one beat
// with the current time, from the S_EMPTY state. A pop that finds a slot
// scans one slot per cycle from the cursor (the S_SCAN state), then for each
// stored event reads it (S_EVRD) and gives a beat (S_EVOUT), the final one
// marked last. One request is handled at a time; req_stall is high while an
// item is in progress. The slot fill memory and the event memory each use
// one read and one write port. After reset the block runs a clearing pass
// over every slot of the fill memory with req_stall high. When rsp_stall is
// high the response register holds its beat and the block waits before
// producing the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_event_scheduler_top
   import twes_pkg::*;
#(
   parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
   parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_beat_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_beat_type      rsp_data
);

   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
   localparam int FILL_BITS  = $clog2(BUCKET_DEPTH + 1);
   localparam int K_BITS     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int EV_DEPTH   = SLOT_COUNT * BUCKET_DEPTH;
   localparam int ADDR_BITS  = $clog2(EV_DEPTH);
   localparam int PEND_BITS  = $clog2(EV_DEPTH + 1);
   localparam int CLAMP_BITS = ((SLOT_BITS > AT_BITS) ? SLOT_BITS : AT_BITS) + 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCHED = 3'd2;
   localparam logic [2:0] S_EMPTY = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_EVRD  = 3'd5;
   localparam logic [2:0] S_EVOUT = 3'd6;

   logic [FILL_BITS-1:0]  fill_mem [SLOT_COUNT];
   logic [EVENT_BITS-1:0] ev_mem   [EV_DEPTH];

   logic [2:0]            state_ff, state_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [SLOT_BITS:0]    cursor_ff, cursor_in;
   logic [SLOT_BITS-1:0]  cur_time_ff, cur_time_in;
   logic [PEND_BITS-1:0]  pend_ff, pend_in;
   logic [FILL_BITS-1:0]  cnt_ff, cnt_in;
   logic [K_BITS-1:0]     k_ff, k_in;
   logic [EVENT_BITS-1:0] pay_ff, pay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_ff, rsp_in;

   logic [FILL_BITS-1:0]  fill_q_ff;
   logic [EVENT_BITS-1:0] ev_q_ff;

   logic                  fill_we;
   logic [SLOT_BITS-1:0]  fill_waddr;
   logic [FILL_BITS-1:0]  fill_wdata;
   logic                  ev_we;
   logic [ADDR_BITS-1:0]  ev_waddr;
   logic [ADDR_BITS-1:0]  ev_raddr;

   logic                  take;
   logic                  rsp_free;
   logic [CLAMP_BITS-1:0] at_ext, cur_ext, t_ext;
   logic [SLOT_BITS-1:0]  t_slot;
   logic                  last_ev;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign last_ev   = ({1'b0, k_ff} + (K_BITS + 1)'(1)) == (K_BITS + 1)'(cnt_ff);

   always_comb begin
      at_ext  = CLAMP_BITS'(req_data.slot_time);
      cur_ext = CLAMP_BITS'(cur_time_ff);
      t_ext   = (at_ext < cur_ext) ? cur_ext : at_ext;
      if (t_ext > CLAMP_BITS'(SLOT_COUNT - 1)) begin
         t_ext = CLAMP_BITS'(SLOT_COUNT - 1);
      end
      t_slot = t_ext[SLOT_BITS-1:0];
   end

   assign ev_raddr = ADDR_BITS'(slot_ff) * ADDR_BITS'(BUCKET_DEPTH) + ADDR_BITS'(k_ff);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cursor_in    = cursor_ff;
      cur_time_in  = cur_time_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      pay_in       = pay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      fill_we      = 1'b0;
      fill_waddr   = slot_ff;
      fill_wdata   = '0;
      ev_we        = 1'b0;
      ev_waddr     = ADDR_BITS'(slot_ff) * ADDR_BITS'(BUCKET_DEPTH) + ADDR_BITS'(fill_q_ff);
      case (state_ff)
         S_CLEAR: begin
            fill_we = 1'b1;
            slot_in = slot_ff + SLOT_BITS'(1);
            if (slot_ff == SLOT_BITS'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               pay_in = req_data.event_payload;
               if (req_data.command == CMD_SCHEDULE) begin
                  slot_in  = t_slot;
                  state_in = S_SCHED;
               end else if (pend_ff == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  slot_in  = cursor_ff[SLOT_BITS-1:0];
                  state_in = S_SCAN;
               end
            end
         end
         S_SCHED: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_in.event_second      = SECOND_BITS'(slot_ff);
               rsp_in.event_payload_out = '0;
               rsp_in.last              = 1'b1;
               if (fill_q_ff >= FILL_BITS'(BUCKET_DEPTH)) begin
                  rsp_in.status      = ST_DROPPED;
                  rsp_in.wheel_empty = (pend_ff == '0);
               end else begin
                  ev_we              = 1'b1;
                  fill_we            = 1'b1;
                  fill_wdata         = fill_q_ff + FILL_BITS'(1);
                  pend_in            = pend_ff + PEND_BITS'(1);
                  rsp_in.status      = ST_SCHEDULED;
                  rsp_in.wheel_empty = 1'b0;
                  if ({1'b0, slot_ff} < cursor_ff) begin
                     cursor_in = {1'b0, slot_ff};
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.status            = ST_NONE;
               rsp_in.event_second      = SECOND_BITS'(cur_time_ff);
               rsp_in.event_payload_out = '0;
               rsp_in.last              = 1'b1;
               rsp_in.wheel_empty       = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         S_SCAN: begin
            if (fill_q_ff == '0) begin
               slot_in = slot_ff + SLOT_BITS'(1);
            end else begin
               cnt_in      = fill_q_ff;
               k_in        = '0;
               cur_time_in = slot_ff;
               pend_in     = pend_ff - PEND_BITS'(fill_q_ff);
               state_in    = S_EVRD;
            end
         end
         S_EVRD: begin
            state_in = S_EVOUT;
         end
         S_EVOUT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.status            = ST_DELIVERED;
               rsp_in.event_second      = SECOND_BITS'(slot_ff);
               rsp_in.event_payload_out = ev_q_ff;
               rsp_in.last              = last_ev;
               rsp_in.wheel_empty       = (pend_ff == '0);
               if (last_ev) begin
                  fill_we   = 1'b1;
                  cursor_in = {1'b0, slot_ff} + (SLOT_BITS + 1)'(1);
                  state_in  = S_IDLE;
               end else begin
                  k_in     = k_ff + K_BITS'(1);
                  state_in = S_EVRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_q_ff <= fill_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= pay_ff;
      end
      ev_q_ff <= ev_mem[ev_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_ff      <= '0;
         cursor_ff    <= '0;
         cur_time_ff  <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         cursor_ff    <= cursor_in;
         cur_time_ff  <= cur_time_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
      pay_ff <= pay_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

[dv/timing_wheel_event_scheduler_top_test.sv]
// ----------------------------------------------------------------------------
// Timing wheel event scheduler testbench
// Drives schedule and pop beats under random sender and receiver idling and
// checks every response beat against a behavioral wheel kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module timing_wheel_event_scheduler_top_test;
   import twes_pkg::*;

   localparam int SLOTS = DEF_SLOT_COUNT;
   localparam int DEPTH = DEF_BUCKET_DEPTH;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   timing_wheel_event_scheduler_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   logic [EVENT_BITS-1:0] wheel_words [SLOTS][DEPTH];
   int unsigned           wheel_fill [SLOTS];
   int unsigned           cursor;
   int unsigned           latest;
   bit                    anything_filed;
   int unsigned           now_slot;

   rsp_beat_type expected_beats[$];
   int           send_idle_pct;
   int           recv_idle_pct;
   int           errors;
   int           beats_checked;
   int           items_sent;

   function automatic void skip_empty_slots();
      if (anything_filed)
         while (cursor <= latest && cursor < SLOTS && wheel_fill[cursor] == 0)
            cursor++;
   endfunction

   function automatic bit wheel_idle();
      skip_empty_slots();
      return !anything_filed || cursor > latest || cursor >= SLOTS;
   endfunction

   function automatic void predict_beats(req_beat_type item);
      rsp_beat_type beat;
      rsp_beat_type batch[$];
      int unsigned  slot;
      int unsigned  cnt;
      bit           emp;
      beat = '0;
      if (item.command == CMD_SCHEDULE) begin
         slot = 32'(item.slot_time);
         if (slot < now_slot) slot = now_slot;
         if (slot > SLOTS - 1) slot = SLOTS - 1;
         beat.event_second = SECOND_BITS'(slot);
         beat.last = 1'b1;
         if (wheel_fill[slot] >= DEPTH) begin
            beat.status = ST_DROPPED;
         end else begin
            wheel_words[slot][wheel_fill[slot]] = item.event_payload;
            wheel_fill[slot]++;
            if (!anything_filed || slot > latest) latest = slot;
            anything_filed = 1'b1;
            if (slot < cursor) cursor = slot;
            beat.status = ST_SCHEDULED;
         end
         batch = {batch, beat};
      end else if (wheel_idle()) begin
         beat.status = ST_NONE;
         beat.event_second = SECOND_BITS'(now_slot);
         beat.last = 1'b1;
         batch = {batch, beat};
      end else begin
         slot = cursor;
         cnt = wheel_fill[slot];
         now_slot = slot;
         for (int k = 0; k < cnt; k++) begin
            beat.status = ST_DELIVERED;
            beat.event_second = SECOND_BITS'(slot);
            beat.event_payload_out = wheel_words[slot][k];
            beat.last = (k + 1 == cnt);
            batch = {batch, beat};
         end
         wheel_fill[slot] = 0;
         cursor = slot + 1;
      end
      emp = wheel_idle();
      foreach (batch[i]) begin
         batch[i].wheel_empty = emp;
         expected_beats = {expected_beats, batch[i]};
      end
   endfunction

   task automatic send_item(input logic cmd, input logic [AT_BITS-1:0] at,
                            input logic [EVENT_BITS-1:0] pay);
      req_beat_type item;
      item.command = cmd;
      item.slot_time = at;
      item.event_payload = pay;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beats(item);
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_beats[0]) begin
                  $display("%0t: mismatch expected %h actual %h", $time,
                           expected_beats[0], rsp_data);
                  errors++;
               end
               void'(expected_beats.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [EVENT_BITS-1:0] rand_payload();
      return EVENT_BITS'({$urandom, $urandom});
   endfunction

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(CMD_POP, 16'hFFFF, '1);
      send_item(CMD_SCHEDULE, 16'd0, '0);
      send_item(CMD_SCHEDULE, 16'd0, '1);
      send_item(CMD_SCHEDULE, 16'hFFFF, 48'hAAAA_5555_AAAA);
      send_item(CMD_SCHEDULE, 16'd4095, 48'h5555_AAAA_5555);
      send_item(CMD_SCHEDULE, 16'd20, 48'h1);
      send_item(CMD_POP, 16'd0, '0);
      send_item(CMD_POP, 16'd0, '0);
      send_item(CMD_SCHEDULE, 16'd3, 48'h2);
      send_item(CMD_POP, 16'd0, '0);
      for (int i = 0; i < DEPTH + 1; i++)
         send_item(CMD_SCHEDULE, 16'd30, rand_payload());
      send_item(CMD_POP, 16'd0, '0);
      send_item(CMD_POP, 16'd0, '0);
      send_item(CMD_POP, 16'd0, '0);
      send_item(CMD_POP, 16'd0, '0);
      wait_drain();
   endtask

   task automatic test_random(input int count);
      int unsigned at;
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 35) begin
            send_item(CMD_POP, AT_BITS'($urandom), rand_payload());
         end else begin
            r = $urandom_range(99);
            if (r < 70) at = now_slot + $urandom_range(12);
            else if (r < 80) at = $urandom_range(now_slot);
            else if (r < 90) at = $urandom_range(16'hFFFF);
            else at = now_slot + $urandom_range(2);
            send_item(CMD_SCHEDULE, AT_BITS'(at), rand_payload());
         end
      end
      wait_drain();
   endtask

   initial begin
      foreach (wheel_fill[i]) wheel_fill[i] = 0;
      cursor = 0; latest = 0; anything_filed = 0; now_slot = 0;
      errors = 0; beats_checked = 0; items_sent = 0;
      send_idle_pct = 20;
      recv_idle_pct = 77;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100);
      send_idle_pct = 77;
      recv_idle_pct = 20;
      test_random(100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(110);
      repeat (50) @(posedge clock);
      $display("Sent %0d schedule and pop beats, checked %0d response beats,",
               items_sent, beats_checked);
      $display("covering past and overflow times, full buckets and empty pops.");
      if (errors == 0 && expected_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
